// ===== hw/rtl/glr_pkg.sv =====
// Shared constants and types for the Life row stencil core.
// Used by every module in hw/rtl except glr_cell_lane; depends on nothing.
package glr_pkg;

  localparam int BOARD_COLUMNS = 16;
  localparam int WIDTH_W       = 5;
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_W         = $clog2(FIFO_DEPTH);
  localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

  typedef logic [BOARD_COLUMNS-1:0] row_t;

  typedef struct packed {
    row_t row;
    logic last;
  } word_t;

  // Column c is in use when c < min(width, BOARD_COLUMNS).
  function automatic row_t col_mask(input logic [WIDTH_W-1:0] width);
    row_t m;
    for (int c = 0; c < BOARD_COLUMNS; c++) begin
      m[c] = (c < int'(width));
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/glr_cell_lane.sv =====
// One column lane: B3/S23 rule on a 3x3 neighborhood.
// Depends on nothing.
module glr_cell_lane (
  input  logic [2:0] up,
  input  logic [2:0] mid,
  input  logic [2:0] down,
  output logic       alive
);

  logic [3:0] nbrs;

  assign nbrs = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
              + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);

  assign alive = (nbrs == 4'd3) || (mid[1] && (nbrs == 4'd2));

endmodule

// ===== hw/rtl/glr_row_eval.sv =====
// One lane per column over three rows, then a merge that masks unused columns.
// Depends on glr_pkg and glr_cell_lane.
module glr_row_eval (
  input  glr_pkg::row_t up,
  input  glr_pkg::row_t mid,
  input  glr_pkg::row_t down,
  input  glr_pkg::row_t mask,
  output glr_pkg::row_t result
);

  logic [glr_pkg::BOARD_COLUMNS+1:0] up_ext;
  logic [glr_pkg::BOARD_COLUMNS+1:0] mid_ext;
  logic [glr_pkg::BOARD_COLUMNS+1:0] down_ext;
  glr_pkg::row_t                     lane_out;

  // dead border column on each side
  assign up_ext   = {1'b0, up & mask, 1'b0};
  assign mid_ext  = {1'b0, mid & mask, 1'b0};
  assign down_ext = {1'b0, down & mask, 1'b0};

  for (genvar c = 0; c < glr_pkg::BOARD_COLUMNS; c++) begin : g_lane
    glr_cell_lane u_lane (
      .up    (up_ext[c+2:c]),
      .mid   (mid_ext[c+2:c]),
      .down  (down_ext[c+2:c]),
      .alive (lane_out[c])
    );
  end

  assign result = lane_out & mask;

endmodule

// ===== hw/rtl/glr_out_fifo.sv =====
// Result queue: takes zero, one or two words a cycle, gives one word on each pop.
// Depends on glr_pkg.
module glr_out_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [1:0]              push_n,
  input  glr_pkg::word_t          push_first,
  input  glr_pkg::word_t          push_second,
  input  logic                    pop,
  output logic                    not_empty,
  output logic                    near_full,
  output glr_pkg::word_t          head
);

  glr_pkg::word_t                 entries [glr_pkg::FIFO_DEPTH];
  logic [glr_pkg::PTR_W-1:0]      wr_ptr;
  logic [glr_pkg::PTR_W-1:0]      rd_ptr;
  logic [glr_pkg::CNT_W-1:0]      count;
  logic [glr_pkg::CNT_W-1:0]      count_next;
  logic [glr_pkg::PTR_W-1:0]      wr_ptr_second;

  assign wr_ptr_second = wr_ptr + glr_pkg::PTR_W'(1);
  assign count_next    = count + glr_pkg::CNT_W'(push_n) - glr_pkg::CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + glr_pkg::PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + glr_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push_first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_second] <= push_second;
    end
  end

  assign not_empty = (count != '0);
  // room for two words must remain before taking another row
  assign near_full = (count > glr_pkg::CNT_W'(glr_pkg::FIFO_DEPTH - 2));
  assign head      = entries[rd_ptr];

endmodule

// ===== hw/rtl/life_generation_row_stencil_core.sv =====
// Game of Life (B3/S23) generation over a board streamed one row per word.
// A result word is pushed into the output queue when the row that causes it is accepted.
// Throughput: one row per cycle; the extra word of a last row is absorbed by
// the next board's first row, so in_stall rises only under output stalls.
// Reset (rst, synchronous): row history and queue cleared, width = 16.
module life_generation_row_stencil_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [glr_pkg::WIDTH_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  glr_pkg::row_t                 row_cells,
  input  logic                          last_row,
  output logic                          out_valid,
  input  logic                          out_stall,
  output glr_pkg::row_t                 next_row,
  output logic                          board_end
);

  logic [glr_pkg::WIDTH_W-1:0] width_in_use;
  glr_pkg::row_t               row_above;
  glr_pkg::row_t               row_middle;
  logic                        held;

  glr_pkg::row_t  mask;
  glr_pkg::row_t  row_in;
  glr_pkg::row_t  above_b;
  glr_pkg::row_t  eval_a;
  glr_pkg::row_t  eval_b;
  logic           accept;
  logic           pop;
  logic [1:0]     push_n;
  glr_pkg::word_t push_first;
  glr_pkg::word_t push_second;
  glr_pkg::word_t head;
  logic           near_full;

  assign mask    = glr_pkg::col_mask(width_in_use);
  assign row_in  = row_cells & mask;
  assign accept  = in_valid && !in_stall;
  assign above_b = held ? row_middle : '0;

  // row above, given the new row as the one below
  glr_row_eval u_eval_mid (
    .up     (row_above),
    .mid    (row_middle),
    .down   (row_in),
    .mask   (mask),
    .result (eval_a)
  );

  // new row itself with a dead row below (end of board)
  glr_row_eval u_eval_last (
    .up     (above_b),
    .mid    (row_in),
    .down   ('0),
    .mask   (mask),
    .result (eval_b)
  );

  always_comb begin
    push_n      = 2'd0;
    push_first  = '{row: eval_b, last: 1'b1};
    push_second = '{row: eval_b, last: 1'b1};
    if (accept) begin
      push_n = 2'(held) + 2'(last_row);
      if (held) begin
        push_first = '{row: eval_a, last: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= glr_pkg::WIDTH_W'(glr_pkg::BOARD_COLUMNS);
      row_above    <= '0;
      row_middle   <= '0;
      held         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        width_in_use <= cfg_wr_data;
      end
      if (accept) begin
        if (last_row) begin
          row_above  <= '0;
          row_middle <= '0;
          held       <= 1'b0;
        end else begin
          row_above  <= above_b;
          row_middle <= row_in;
          held       <= 1'b1;
        end
      end
    end
  end

  glr_out_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_n      (push_n),
    .push_first  (push_first),
    .push_second (push_second),
    .pop         (pop),
    .not_empty   (out_valid),
    .near_full   (near_full),
    .head        (head)
  );

  assign pop       = out_valid && !out_stall;
  assign in_stall  = near_full;
  assign next_row  = head.row;
  assign board_end = head.last;

endmodule

// ===== hw/rtl/glr_checker.sv =====
// Port-level checks for the Life row stencil core, bound to the top level.
// Depends on glr_pkg and life_generation_row_stencil_core ports only.
module glr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        last_row,
  input logic                        out_valid,
  input logic                        out_stall,
  input glr_pkg::row_t               next_row,
  input logic                        board_end
);

  // queue is empty after reset
  assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("core not idle after reset");

  // a waiting word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_row) && $stable(board_end))
    else $error("stalled result word changed");

  // one-row board right after reset gives a final word next cycle
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) && in_valid && !in_stall && last_row |=> out_valid && board_end)
    else $error("one-row board did not end the board");

  // first row of a board after reset gives no word
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !(in_valid && !in_stall && last_row) |=> !out_valid)
    else $error("result word without a completed row pair");

endmodule

bind life_generation_row_stencil_core glr_checker u_glr_checker (.*);
